// ----- rtl/sorted_key_count_merger_macros.svh -----
// Assertion macros for the checker file.
`ifndef SORTED_KEY_COUNT_MERGER_MACROS_SVH
`define SORTED_KEY_COUNT_MERGER_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define SKCM_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SKCM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/skcm_pkg.sv -----
// Shared types and codes for the sorted key count merger.
package skcm_pkg;
   localparam logic [1:0] ACT_ADD       = 2'd0;
   localparam logic [1:0] ACT_FINISH    = 2'd1;
   localparam logic [1:0] ACT_READ_BKT  = 2'd2;
   localparam logic [1:0] ACT_READ_HIST = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_RECORD = 2'd1;
   localparam logic [1:0] KIND_ORDER  = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   localparam int BKT_ADDR_BITS = 12;
   localparam int BKT_DEPTH     = 4096;
   localparam int HIST_ADDR_BITS = 10;
   localparam int HIST_DEPTH_C   = 1024;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] key_prefix;
      logic [43:0] key_suffix;
      logic [31:0] add_count;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] rec_prefix;
      logic [43:0] rec_suffix;
      logic [31:0] rec_count;
      logic [63:0] read_data;
      logic [63:0] distinct_keys;
      logic [63:0] unique_keys;
      logic [63:0] total_count;
      logic [31:0] largest_count;
   } rsp_type;

   // Classified operation passed from front to back.
   typedef struct packed {
      logic [1:0]  kind;
      logic        emit;
      logic        rd_hist;
      logic        rd_zero;
      logic [11:0] rec_prefix;
      logic [43:0] rec_suffix;
      logic [31:0] rec_count;
      logic [11:0] read_index;
   } op_type;
endpackage

// ----- rtl/sorted_key_count_merger.sv -----
// Top level of the sorted key count merger.
//   channel | direction | handshake     | payload
//   req     | in        | push / full   | req_type
//   rsp     | out       | empty / pop   | rsp_type
// One item per cycle unless stalled; a result passes the front register and stage 1.
// The bucket and histogram memories are read one cycle and written back the
// next, with forwarding so back-to-back records see the newest values.
// After reset a clearing pass that zeroes every bucket and histogram entry stalls the
// back end; the front register takes one transfer, then full stays high until it ends.
// A stalled result side fills the two-entry queue and the front register, then full rises.
module sorted_key_count_merger
   import skcm_pkg::*;
#(
   parameter int PREFIX_BITS = 12,
   parameter int SUFFIX_BITS = 44,
   parameter int HIST_DEPTH  = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   logic   f_valid, f_in_ready, b_ready;
   op_type f_op;

   assign req_full = !f_in_ready;

   skcm_front #(.PREFIX_BITS(PREFIX_BITS), .SUFFIX_BITS(SUFFIX_BITS),
                .HIST_DEPTH(HIST_DEPTH)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_push), .in_req(req_data),
      .out_valid(f_valid), .out_op(f_op), .out_ready(b_ready), .in_ready(f_in_ready)
   );

   skcm_back #(.PREFIX_BITS(PREFIX_BITS), .HIST_DEPTH(HIST_DEPTH)) u_back (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_op(f_op),
      .in_ready(b_ready), .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );
endmodule

// ----- rtl/skcm_front.sv -----
// Front end: order check, merge of equal keys, classification.
module skcm_front
   import skcm_pkg::*;
#(
   parameter int PREFIX_BITS = 12,
   parameter int SUFFIX_BITS = 44,
   parameter int HIST_DEPTH  = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    out_valid,
   output op_type  out_op,
   input  logic    out_ready,
   output logic    in_ready
);
   logic [11:0] pend_pre_ff, pend_pre_in;
   logic [43:0] pend_suf_ff, pend_suf_in;
   logic [31:0] pend_cnt_ff, pend_cnt_in;
   logic        valid_ff, valid_in;
   op_type      op_ff, op_in;
   logic [11:0] pre;
   logic [43:0] suf;
   logic [32:0] sum;
   logic        take;

   assign pre = in_req.key_prefix & 12'((64'd1 << PREFIX_BITS) - 64'd1);
   assign suf = in_req.key_suffix & 44'((SUFFIX_BITS >= 64) ? ~64'd0
                                         : ((64'd1 << SUFFIX_BITS) - 64'd1));
   assign sum = {1'b0, pend_cnt_ff} + {1'b0, in_req.add_count};
   assign in_ready = !valid_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_op = op_ff;

   // Classify the item and advance the pending key.
   always_comb begin
      pend_pre_in = pend_pre_ff;
      pend_suf_in = pend_suf_ff;
      pend_cnt_in = pend_cnt_ff;
      op_in = '0;
      op_in.rec_prefix = pend_pre_ff;
      op_in.rec_suffix = pend_suf_ff;
      op_in.rec_count  = pend_cnt_ff;
      op_in.read_index = in_req.read_index;
      unique case (in_req.action)
         ACT_ADD: begin
            if (pre < pend_pre_ff || (pre == pend_pre_ff && suf < pend_suf_ff)) begin
               op_in.kind = KIND_ORDER;
            end else if (pre == pend_pre_ff && suf == pend_suf_ff) begin
               pend_cnt_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
               op_in.emit = (pend_cnt_ff != '0);
               op_in.kind = op_in.emit ? KIND_RECORD : KIND_NONE;
               pend_pre_in = pre;
               pend_suf_in = suf;
               pend_cnt_in = in_req.add_count;
            end
         end
         ACT_FINISH: begin
            op_in.emit = (pend_cnt_ff != '0);
            op_in.kind = op_in.emit ? KIND_RECORD : KIND_NONE;
            pend_pre_in = '0;
            pend_suf_in = '0;
            pend_cnt_in = '0;
         end
         ACT_READ_BKT: begin
            op_in.kind = KIND_READ;
         end
         ACT_READ_HIST: begin
            op_in.kind = KIND_READ;
            op_in.rd_hist = 1'b1;
            op_in.rd_zero = (32'(in_req.read_index) >= 32'(HIST_DEPTH));
         end
         default: op_in.kind = KIND_NONE;
      endcase
      if (!op_in.emit) begin
         op_in.rec_prefix = '0;
         op_in.rec_suffix = '0;
         op_in.rec_count  = '0;
      end
   end

   // Hold the classified op until the back end takes it.
   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_pre_ff <= '0;
         pend_suf_ff <= '0;
         pend_cnt_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            pend_pre_ff <= pend_pre_in;
            pend_suf_ff <= pend_suf_in;
            pend_cnt_ff <= pend_cnt_in;
         end
      end
      if (take) op_ff <= op_in;
   end
endmodule

// ----- rtl/skcm_back.sv -----
// Back end: bucket and histogram memories, statistics, result queue.
module skcm_back
   import skcm_pkg::*;
#(
   parameter int PREFIX_BITS = 12,
   parameter int HIST_DEPTH  = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  op_type  in_op,
   output logic    in_ready,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);
   localparam int NB = 1 << PREFIX_BITS;
   localparam int BA = PREFIX_BITS;
   localparam int HA = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CA = (NB > HIST_DEPTH) ? BA : HA;
   localparam logic [CA:0] CLR_END = (CA+1)'((NB > HIST_DEPTH) ? NB : HIST_DEPTH);

   logic [31:0] bkt_mem [NB];
   logic [63:0] hist_mem [HIST_DEPTH];

   // Clearing pass after reset.
   logic          clr_ff;
   logic [CA:0]   clr_cnt_ff;

   // Stage 1: read memories.
   logic          s1_v_ff;
   op_type        s1_op_ff;
   logic [BA-1:0] s1_ba_ff;
   logic [HA-1:0] s1_ha_ff;
   logic [31:0]   bkt_rd_ff;
   logic [63:0]   hist_rd_ff;

   // Stage 2 write-back registers for forwarding.
   logic          wb_b_ff, wb_h_ff;
   logic [BA-1:0] wb_ba_ff;
   logic [HA-1:0] wb_ha_ff;
   logic [31:0]   wb_bd_ff;
   logic [63:0]   wb_hd_ff;

   logic [63:0] dist_ff, uniq_ff, sum_ff;
   logic [31:0] max_ff;

   // Output queue of two entries.
   rsp_type q_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ptr_ff, wr_ptr_ff;

   logic          go, push, pop;
   logic [BA-1:0] ba;
   logic [HA-1:0] ha, s1_ha_cur;
   logic [31:0]   bcur, bnew;
   logic [63:0]   hcur, hnew;
   rsp_type       r;
   logic [1:0]    inflight;

   assign pop = rsp_pop && cnt_ff != '0;
   assign inflight = cnt_ff + {1'b0, s1_v_ff};
   assign in_ready = !clr_ff && (inflight < 2'd2 || (pop && inflight == 2'd2));
   assign go = in_valid && in_ready;
   assign push = s1_v_ff;
   assign ba = in_op.emit ? BA'(in_op.rec_prefix) : BA'(in_op.read_index);
   // Histogram bin of record count, top bin saturating.
   assign ha = in_op.emit ?
      ((in_op.rec_count >= 32'(HIST_DEPTH - 1)) ? HA'(HIST_DEPTH - 1) : HA'(in_op.rec_count))
      : HA'(in_op.read_index);
   assign s1_ha_cur = s1_ha_ff;

   // Forward the newest write over the registered read.
   always_comb begin
      bcur = (wb_b_ff && wb_ba_ff == s1_ba_ff) ? wb_bd_ff : bkt_rd_ff;
      hcur = (wb_h_ff && wb_ha_ff == s1_ha_cur) ? wb_hd_ff : hist_rd_ff;
      bnew = (bcur == 32'hFFFF_FFFF) ? bcur : bcur + 32'd1;
      hnew = hcur + 64'd1;
   end

   // Build the result of stage 1.
   always_comb begin
      r = '0;
      r.kind = s1_op_ff.kind;
      r.rec_prefix = s1_op_ff.rec_prefix;
      r.rec_suffix = s1_op_ff.rec_suffix;
      r.rec_count  = s1_op_ff.rec_count;
      r.distinct_keys = dist_ff;
      r.unique_keys = uniq_ff;
      r.total_count = sum_ff;
      r.largest_count = max_ff;
      if (s1_op_ff.kind == KIND_READ) begin
         if (!s1_op_ff.rd_hist) r.read_data = {32'd0, bcur};
         else if (!s1_op_ff.rd_zero) r.read_data = hcur;
      end
      if (s1_op_ff.emit) begin
         r.distinct_keys = dist_ff + 64'd1;
         r.unique_keys = uniq_ff + ((s1_op_ff.rec_count == 32'd1) ? 64'd1 : 64'd0);
         r.total_count = sum_ff + {32'd0, s1_op_ff.rec_count};
         r.largest_count = (s1_op_ff.rec_count > max_ff) ? s1_op_ff.rec_count : max_ff;
      end
   end

   // Memories: read in stage 0, write back from stage 1 or clear.
   always_ff @(posedge clock) begin
      bkt_rd_ff <= bkt_mem[ba];
      hist_rd_ff <= hist_mem[ha];
      if (clr_ff) begin
         if (clr_cnt_ff < (CA+1)'(NB)) bkt_mem[clr_cnt_ff[BA-1:0]] <= '0;
         if (clr_cnt_ff < (CA+1)'(HIST_DEPTH)) hist_mem[clr_cnt_ff[HA-1:0]] <= '0;
      end else if (s1_v_ff && s1_op_ff.emit) begin
         bkt_mem[s1_ba_ff] <= bnew;
         hist_mem[s1_ha_ff] <= hnew;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         s1_v_ff <= 1'b0;
         wb_b_ff <= 1'b0;
         wb_h_ff <= 1'b0;
         dist_ff <= '0;
         uniq_ff <= '0;
         sum_ff <= '0;
         max_ff <= '0;
         cnt_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff + 1'b1 == CLR_END) clr_ff <= 1'b0;
         end
         s1_v_ff <= go;
         wb_b_ff <= s1_v_ff && s1_op_ff.emit;
         wb_h_ff <= s1_v_ff && s1_op_ff.emit;
         if (s1_v_ff && s1_op_ff.emit) begin
            dist_ff <= r.distinct_keys;
            uniq_ff <= r.unique_keys;
            sum_ff <= r.total_count;
            max_ff <= r.largest_count;
         end
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (go) begin
         s1_op_ff <= in_op;
         s1_ba_ff <= ba;
         s1_ha_ff <= ha;
      end
      wb_ba_ff <= s1_ba_ff;
      wb_ha_ff <= s1_ha_ff;
      wb_bd_ff <= bnew;
      wb_hd_ff <= hnew;
      if (push) q_ff[wr_ptr_ff] <= r;
   end

   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data = q_ff[rd_ptr_ff];
endmodule

// ----- rtl/skcm_checker.sv -----
// Port-level checker for the sorted key count merger, with its bind.
`include "sorted_key_count_merger_macros.svh"
module skcm_checker
   import skcm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);
   `SKCM_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_data) && !rsp_empty, "result changed while waiting")
   `SKCM_ASSERT_IMPL(a_rec_zero, clock, reset, !rsp_empty && rsp_data.kind != KIND_RECORD, rsp_data.rec_count == '0, "record count nonzero without record")
   `SKCM_ASSERT_IMPL(a_rec_cnt, clock, reset, !rsp_empty && rsp_data.kind == KIND_RECORD, rsp_data.rec_count != '0 && rsp_data.distinct_keys != '0, "empty record emitted")
   `SKCM_ASSERT_IMPL(a_read_zero, clock, reset, !rsp_empty && rsp_data.kind != KIND_READ, rsp_data.read_data == '0, "read data without read")
endmodule

bind sorted_key_count_merger skcm_checker u_skcm_checker (
   .clock(clock), .reset(reset),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
);
